// ===== hw/rtl/gpsp_pkg.sv =====
// shared types and constants for the grid point store
`timescale 1ns / 1ps
package gpsp_pkg;

   localparam int ROW_BITS   = 5;
   localparam int COL_BITS   = 5;
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int CELLS      = 1 << ADDR_BITS;
   localparam int COORD_BITS = 24;
   localparam int WORD_BITS  = 3 * COORD_BITS;
   localparam int CNT_BITS   = 6;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int DIST_BITS  = SQ_BITS + 2;

   localparam logic [CNT_BITS-1:0] MAX_ROWS = 6'd32;
   localparam logic [CNT_BITS-1:0] MAX_COLS = 6'd32;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PATH  = 2'd1;
   localparam logic [1:0] OP_NEAR  = 2'd2;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                last;
   } tag_type;

   typedef struct packed {
      logic                valid;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } near_res_type;

endpackage

// ===== hw/rtl/grid_point_store_path_nearest.sv =====
// top level: grid point store with path readout and nearest point search
`timescale 1ns / 1ps
// A 32 by 32 grid of signed Q15.8 points in one 1024 x 72 bit ram. After reset
// the block runs a clearing pass over all 1024 cells with busy high; register
// writes are taken meanwhile. An item is taken when start is high and busy is
// low. A write, an out of range item and a nearest query on an empty grid
// finish in the transfer cycle and give their result in the next cycle, with
// busy staying low. A path of n points reads one cell per cycle and the points
// come out on consecutive cycles. A nearest query over R x C cells reads one
// cell per cycle into a three stage distance pipeline. The single ram read
// port sets the rate of both. Results carry rsp_valid for one cycle and cannot
// be held.
module grid_point_store_path_nearest (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_op,
   input  logic [gpsp_pkg::ROW_BITS-1:0]         req_row,
   input  logic [gpsp_pkg::COL_BITS-1:0]         req_col,
   input  logic [gpsp_pkg::ROW_BITS-1:0]         req_end_row,
   input  logic [gpsp_pkg::COL_BITS-1:0]         req_end_col,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] req_pos_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_status,
   output logic [gpsp_pkg::ROW_BITS-1:0]         rsp_out_row,
   output logic [gpsp_pkg::COL_BITS-1:0]         rsp_out_col,
   output logic signed [gpsp_pkg::COORD_BITS-1:0] rsp_out_x,
   output logic signed [gpsp_pkg::COORD_BITS-1:0] rsp_out_y,
   output logic signed [gpsp_pkg::COORD_BITS-1:0] rsp_out_z,
   output logic                                  rsp_last,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [2:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int RB = gpsp_pkg::ROW_BITS;
   localparam int CB = gpsp_pkg::COL_BITS;
   localparam int NB = gpsp_pkg::CNT_BITS;
   localparam int XB = gpsp_pkg::COORD_BITS;
   localparam int AB = gpsp_pkg::ADDR_BITS;
   localparam int WB = gpsp_pkg::WORD_BITS;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PATH  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_NEAR  = 3'd4;
   localparam logic [2:0] ST_NWAIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [NB-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [NB-1:0] nr, nc;
   logic [AB-1:0] clr_ff, clr_in;
   logic [RB-1:0] cr_ff, cr_in, er_ff, er_in;
   logic [CB-1:0] cc_ff, cc_in, ec_ff, ec_in;
   logic row_dn_ff, row_dn_in, col_dn_ff, col_dn_in;
   logic signed [XB-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   gpsp_pkg::tag_type rd_tag_ff, rd_tag_in, near_tag;
   logic rd_path_ff, rd_path_in;
   gpsp_pkg::near_res_type near_res;
   logic scan_start;

   logic ram_we;
   logic [AB-1:0] ram_waddr, ram_raddr;
   logic [WB-1:0] ram_wdata, ram_rdata;

   logic accept, cfg_wr, wr_ok, path_ok;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in, rsp_last_ff, rsp_last_in;
   logic [RB-1:0] rsp_row_ff, rsp_row_in;
   logic [CB-1:0] rsp_col_ff, rsp_col_in;
   logic [WB-1:0] rsp_data_ff, rsp_data_in;

   assign nr = (rows_ff > gpsp_pkg::MAX_ROWS) ? gpsp_pkg::MAX_ROWS : rows_ff;
   assign nc = (cols_ff > gpsp_pkg::MAX_COLS) ? gpsp_pkg::MAX_COLS : cols_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_ok  = ({1'b0, req_row} < nr) && ({1'b0, req_col} < nc);
   assign path_ok = wr_ok && ({1'b0, req_end_row} < nr) && ({1'b0, req_end_col} < nc);

   // register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == gpsp_pkg::REG_COLS) ? {26'd0, cols_ff} : {26'd0, rows_ff};

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (cfg_wr) begin
         if (paddr[2] == gpsp_pkg::REG_ROWS) begin
            rows_in = pwdata[NB-1:0];
         end else begin
            cols_in = pwdata[NB-1:0];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cr_in       = cr_ff;
      cc_in       = cc_ff;
      er_in       = er_ff;
      ec_in       = ec_ff;
      row_dn_in   = row_dn_ff;
      col_dn_in   = col_dn_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      qz_in       = qz_ff;
      rd_tag_in   = '0;
      rd_path_in  = 1'b0;
      scan_start  = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = {req_row, req_col};
      ram_wdata   = {req_pos_x, req_pos_y, req_pos_z};
      ram_raddr   = {cr_ff, cc_ff};
      rsp_valid_in  = 1'b0;
      rsp_status_in = gpsp_pkg::STATUS_OK;
      rsp_row_in    = '0;
      rsp_col_in    = '0;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  gpsp_pkg::OP_WRITE: begin
                     ram_we        = wr_ok;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = wr_ok ? gpsp_pkg::STATUS_OK : gpsp_pkg::STATUS_RANGE;
                     rsp_row_in    = req_row;
                     rsp_col_in    = req_col;
                  end
                  gpsp_pkg::OP_PATH: begin
                     if (!path_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = gpsp_pkg::STATUS_RANGE;
                     end else begin
                        cr_in     = req_row;
                        cc_in     = req_col;
                        er_in     = req_end_row;
                        ec_in     = req_end_col;
                        row_dn_in = (req_row > req_end_row);
                        col_dn_in = (req_col > req_end_col);
                        state_in  = ST_PATH;
                     end
                  end
                  gpsp_pkg::OP_NEAR: begin
                     if ((nr == '0) || (nc == '0)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        qx_in      = req_pos_x;
                        qy_in      = req_pos_y;
                        qz_in      = req_pos_z;
                        cr_in      = '0;
                        cc_in      = '0;
                        scan_start = 1'b1;
                        state_in   = ST_NEAR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PATH: begin
            rd_tag_in.valid = 1'b1;
            rd_tag_in.row   = cr_ff;
            rd_tag_in.col   = cc_ff;
            rd_path_in      = 1'b1;
            // rows first, then columns
            if (cr_ff != er_ff) begin
               cr_in = row_dn_ff ? cr_ff - 1'b1 : cr_ff + 1'b1;
            end else if (cc_ff != ec_ff) begin
               cc_in = col_dn_ff ? cc_ff - 1'b1 : cc_ff + 1'b1;
            end else begin
               rd_tag_in.last = 1'b1;
               state_in       = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_NEAR: begin
            rd_tag_in.valid = 1'b1;
            rd_tag_in.row   = cr_ff;
            rd_tag_in.col   = cc_ff;
            if ({1'b0, cc_ff} == nc - 1'b1) begin
               cc_in = '0;
               cr_in = cr_ff + 1'b1;
               if ({1'b0, cr_ff} == nr - 1'b1) begin
                  rd_tag_in.last = 1'b1;
                  state_in       = ST_NWAIT;
               end
            end else begin
               cc_in = cc_ff + 1'b1;
            end
         end
         ST_NWAIT: begin
            if (near_res.valid) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = near_res.row;
               rsp_col_in   = near_res.col;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // path data returns in the cycle after the read
      if (rd_tag_ff.valid && rd_path_ff) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = rd_tag_ff.row;
         rsp_col_in   = rd_tag_ff.col;
         rsp_data_in  = ram_rdata;
         rsp_last_in  = rd_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= gpsp_pkg::MAX_ROWS;
         cols_ff      <= gpsp_pkg::MAX_COLS;
         rd_tag_ff    <= '0;
         rd_path_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rd_tag_ff    <= rd_tag_in;
         rd_path_ff   <= rd_path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cr_ff         <= cr_in;
      cc_ff         <= cc_in;
      er_ff         <= er_in;
      ec_ff         <= ec_in;
      row_dn_ff     <= row_dn_in;
      col_dn_ff     <= col_dn_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      qz_ff         <= qz_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   gpsp_ram #(
      .WIDTH(WB),
      .DEPTH(gpsp_pkg::CELLS)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      near_tag       = rd_tag_ff;
      near_tag.valid = rd_tag_ff.valid && !rd_path_ff;
   end

   gpsp_near u_near (
      .clock     (clock),
      .reset     (reset),
      .scan_start(scan_start),
      .tag_in    (near_tag),
      .rd_word   (ram_rdata),
      .qx        (qx_ff),
      .qy        (qy_ff),
      .qz        (qz_ff),
      .res       (near_res)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_out_x   = rsp_data_ff[3*XB-1:2*XB];
   assign rsp_out_y   = rsp_data_ff[2*XB-1:XB];
   assign rsp_out_z   = rsp_data_ff[XB-1:0];
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff && !rd_tag_ff.valid)
      else $error("result during clearing pass");

   a_ram_write_when_free: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_IDLE))
      else $error("ram write while a query reads");

   a_path_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PATH && rd_tag_in.last) |=> (state_ff == ST_DRAIN) && rd_tag_ff.last)
      else $error("path end not followed by drain");

   a_near_in_wait: assert property (@(posedge clock) disable iff (reset)
      near_res.valid |-> (state_ff == ST_NWAIT))
      else $error("nearest result outside wait state");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_tag_ff.valid)
      else $error("read still in flight while idle");
`endif

endmodule

// ===== hw/rtl/gpsp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module gpsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/gpsp_near.sv =====
// squared distance pipeline and running minimum for the nearest query
`timescale 1ns / 1ps
module gpsp_near (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                scan_start,
   input  gpsp_pkg::tag_type                   tag_in,
   input  logic [gpsp_pkg::WORD_BITS-1:0]      rd_word,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] qx,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] qy,
   input  logic signed [gpsp_pkg::COORD_BITS-1:0] qz,
   output gpsp_pkg::near_res_type              res
);

   localparam int CB = gpsp_pkg::COORD_BITS;

   logic signed [CB-1:0] gx, gy, gz;
   logic signed [gpsp_pkg::DIFF_BITS-1:0] dx, dy, dz;
   logic signed [2*gpsp_pkg::DIFF_BITS-1:0] px, py, pz;

   logic [gpsp_pkg::SQ_BITS-1:0] sqx_ff, sqy_ff, sqz_ff;
   gpsp_pkg::tag_type t1_ff, t2_ff;
   logic [gpsp_pkg::DIST_BITS-1:0] sum_in, sum_ff;
   logic [gpsp_pkg::DIST_BITS-1:0] best_ff, best_in;
   logic [gpsp_pkg::ROW_BITS-1:0] brow_ff, brow_in;
   logic [gpsp_pkg::COL_BITS-1:0] bcol_ff, bcol_in;
   logic found_ff, found_in;
   logic better;
   gpsp_pkg::near_res_type res_ff, res_in;

   assign gx = rd_word[3*CB-1:2*CB];
   assign gy = rd_word[2*CB-1:CB];
   assign gz = rd_word[CB-1:0];

   // difference of two Q15.8 values always fits one extra bit
   assign dx = {qx[CB-1], qx} - {gx[CB-1], gx};
   assign dy = {qy[CB-1], qy} - {gy[CB-1], gy};
   assign dz = {qz[CB-1], qz} - {gz[CB-1], gz};
   assign px = dx * dx;
   assign py = dy * dy;
   assign pz = dz * dz;

   assign sum_in = gpsp_pkg::DIST_BITS'(sqx_ff) + gpsp_pkg::DIST_BITS'(sqy_ff)
                 + gpsp_pkg::DIST_BITS'(sqz_ff);

   // strictly smaller wins so ties keep the earlier cell
   assign better = !found_ff || (sum_ff < best_ff);

   always_comb begin
      best_in  = best_ff;
      brow_in  = brow_ff;
      bcol_in  = bcol_ff;
      found_in = found_ff;
      res_in   = '0;
      if (t2_ff.valid && better) begin
         best_in  = sum_ff;
         brow_in  = t2_ff.row;
         bcol_in  = t2_ff.col;
         found_in = 1'b1;
      end
      if (t2_ff.valid && t2_ff.last) begin
         res_in.valid = 1'b1;
         res_in.row   = better ? t2_ff.row : brow_ff;
         res_in.col   = better ? t2_ff.col : bcol_ff;
      end
      if (scan_start) begin
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff    <= '0;
         t2_ff    <= '0;
         found_ff <= 1'b0;
         res_ff   <= '0;
      end else begin
         t1_ff    <= tag_in;
         t2_ff    <= t1_ff;
         found_ff <= found_in;
         res_ff   <= res_in;
      end
      sqx_ff  <= px[gpsp_pkg::SQ_BITS-1:0];
      sqy_ff  <= py[gpsp_pkg::SQ_BITS-1:0];
      sqz_ff  <= pz[gpsp_pkg::SQ_BITS-1:0];
      sum_ff  <= sum_in;
      best_ff <= best_in;
      brow_ff <= brow_in;
      bcol_ff <= bcol_in;
   end

   assign res = res_ff;

`ifndef SYNTHESIS
   a_res_needs_last: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> $past(t2_ff.valid) && $past(t2_ff.last))
      else $error("nearest result without a final sample");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (t1_ff.valid && t2_ff.valid && !t2_ff.last) |->
         ({t1_ff.row, t1_ff.col} > {t2_ff.row, t2_ff.col}))
      else $error("nearest scan out of row-major order");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |=> !res_ff.valid)
      else $error("nearest result repeated");
`endif

endmodule

// ===== sim/tb_grid_point_store_path_nearest.sv =====
// testbench for the grid point store with path readout and nearest point search
`timescale 1ns / 1ps
module tb_grid_point_store_path_nearest;
   import gpsp_pkg::*;

   typedef struct packed {
      logic                          status;
      logic [ROW_BITS-1:0]           row;
      logic [COL_BITS-1:0]           col;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic signed [COORD_BITS-1:0]  z;
      logic                          last;
   } grid_result_type;

   // op code with no operation behind it
   localparam logic [1:0] OP_NONE = 2'd3;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_op = OP_WRITE;
   logic [ROW_BITS-1:0]           req_row = '0;
   logic [COL_BITS-1:0]           req_col = '0;
   logic [ROW_BITS-1:0]           req_end_row = '0;
   logic [COL_BITS-1:0]           req_end_col = '0;
   logic signed [COORD_BITS-1:0]  req_pos_x = '0;
   logic signed [COORD_BITS-1:0]  req_pos_y = '0;
   logic signed [COORD_BITS-1:0]  req_pos_z = '0;
   logic                          rsp_valid;
   logic                          rsp_status;
   logic [ROW_BITS-1:0]           rsp_out_row;
   logic [COL_BITS-1:0]           rsp_out_col;
   logic signed [COORD_BITS-1:0]  rsp_out_x;
   logic signed [COORD_BITS-1:0]  rsp_out_y;
   logic signed [COORD_BITS-1:0]  rsp_out_z;
   logic                          rsp_last;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [2:0]                    paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // own copy of the grid and the two count registers
   logic signed [COORD_BITS-1:0] grid_px [CELLS];
   logic signed [COORD_BITS-1:0] grid_py [CELLS];
   logic signed [COORD_BITS-1:0] grid_pz [CELLS];
   logic [CNT_BITS-1:0]          rows_reg = 6'd32;
   logic [CNT_BITS-1:0]          cols_reg = 6'd32;

   grid_result_type pending_results [$];
   int           mismatch_count = 0;
   int           sender_idle_pct = 0;

   grid_point_store_path_nearest i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_end_row (req_end_row),
      .req_end_col (req_end_col),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_last    (rsp_last),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         grid_px[i] = '0;
         grid_py[i] = '0;
         grid_pz[i] = '0;
      end
   end

   function automatic int unsigned eff_count(logic [CNT_BITS-1:0] v);
      return (v > 32) ? 32 : v;
   endfunction

   function automatic longint sq_diff(logic signed [COORD_BITS-1:0] a,
                                      logic signed [COORD_BITS-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   function automatic grid_result_type stored_point(int unsigned r, int unsigned c,
                                                    logic is_last);
      grid_result_type res;
      logic [ADDR_BITS-1:0] slot;
      slot = {r[ROW_BITS-1:0], c[COL_BITS-1:0]};
      res.status = STATUS_OK;
      res.row = r[ROW_BITS-1:0];
      res.col = c[COL_BITS-1:0];
      res.x = grid_px[slot];
      res.y = grid_py[slot];
      res.z = grid_pz[slot];
      res.last = is_last;
      return res;
   endfunction

   // append one expected result at the tail of the queue
   function automatic void add_expected(input grid_result_type res_item);
      pending_results.insert(pending_results.size(), res_item);
   endfunction

   // work out the results of one accepted item and update the grid copy
   task automatic predict_item(input logic [1:0] op, input logic [4:0] r, c, er, ec,
                               input logic signed [COORD_BITS-1:0] px, py, pz);
      int unsigned nr, nc, cr, cc;
      grid_result_type res;
      longint sq_dist, best;
      bit found;
      nr = eff_count(rows_reg);
      nc = eff_count(cols_reg);
      res = '0;
      res.last = 1'b1;
      case (op)
         OP_WRITE: begin
            res.row = r;
            res.col = c;
            if (r >= nr || c >= nc) begin
               res.status = STATUS_RANGE;
            end else begin
               grid_px[{r, c}] = px;
               grid_py[{r, c}] = py;
               grid_pz[{r, c}] = pz;
            end
            add_expected(res);
         end
         OP_PATH: begin
            if (r >= nr || c >= nc || er >= nr || ec >= nc) begin
               res.status = STATUS_RANGE;
               add_expected(res);
            end else begin
               cr = r;
               cc = c;
               // rows first, then columns, end point flagged
               while (cr != er) begin
                  add_expected(stored_point(cr, cc, 1'b0));
                  cr = (r > er) ? cr - 1 : cr + 1;
               end
               while (cc != ec) begin
                  add_expected(stored_point(cr, cc, 1'b0));
                  cc = (c > ec) ? cc - 1 : cc + 1;
               end
               add_expected(stored_point(er, ec, 1'b1));
            end
         end
         OP_NEAR: begin
            found = 1'b0;
            best = 0;
            for (int unsigned i = 0; i < nr; i++) begin
               for (int unsigned j = 0; j < nc; j++) begin
                  sq_dist = sq_diff(px, grid_px[{i[4:0], j[4:0]}])
                          + sq_diff(py, grid_py[{i[4:0], j[4:0]}])
                          + sq_diff(pz, grid_pz[{i[4:0], j[4:0]}]);
                  // strictly smaller wins, ties keep the earlier one
                  if (!found || sq_dist < best) begin
                     found = 1'b1;
                     best = sq_dist;
                     res.row = i[4:0];
                     res.col = j[4:0];
                  end
               end
            end
            add_expected(res);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : check_results
      grid_result_type got;
      grid_result_type want;
      if (!reset && rsp_valid) begin
         got.status = rsp_status;
         got.row = rsp_out_row;
         got.col = rsp_out_col;
         got.x = rsp_out_x;
         got.y = rsp_out_y;
         got.z = rsp_out_z;
         got.last = rsp_last;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result st=%0d r=%0d c=%0d x=%0d y=%0d z=%0d last=%0d",
                        got.status, got.row, got.col, $signed(got.x), $signed(got.y),
                        $signed(got.z), got.last);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch at %0t", $realtime);
                  $display("  exp st=%0d r=%0d c=%0d x=%0d y=%0d z=%0d last=%0d",
                           want.status, want.row, want.col, $signed(want.x),
                           $signed(want.y), $signed(want.z), want.last);
                  $display("  got st=%0d r=%0d c=%0d x=%0d y=%0d z=%0d last=%0d",
                           got.status, got.row, got.col, $signed(got.x),
                           $signed(got.y), $signed(got.z), got.last);
               end
            end
         end
      end
   end

   task automatic csr_write(input logic reg_sel, input logic [CNT_BITS-1:0] value);
      logic [31:0] data;
      data = $urandom();
      data[CNT_BITS-1:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (reg_sel == REG_ROWS)
         rows_reg = value;
      else
         cols_reg = value;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic reg_sel);
      logic [31:0] want;
      want = {26'd0, (reg_sel == REG_ROWS) ? rows_reg : cols_reg};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("register %0d read: exp %0d got %0d", reg_sel, want, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid_size(input logic [CNT_BITS-1:0] rows, cols);
      csr_write(REG_ROWS, rows);
      csr_write(REG_COLS, cols);
      csr_read(REG_ROWS);
      csr_read(REG_COLS);
   endtask

   // start stays high across back to back transfers
   task automatic send_item(input logic [1:0] op, input logic [4:0] r, c, er, ec,
                            input logic signed [COORD_BITS-1:0] px, py, pz);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_row <= r;
      req_col <= c;
      req_end_row <= er;
      req_end_col <= ec;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (busy);
      predict_item(op, r, c, er, ec, px, py, pz);
   endtask

   task automatic drain_results();
      int n;
      n = 0;
      start <= 1'b0;
      while ((pending_results.size() != 0 || busy) && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(9))
         0, 1, 2, 3: return v[COORD_BITS-1:0];
         4, 5, 6:    return COORD_BITS'($urandom_range(2047) - 1024);
         7, 8: begin
            case (v[1:0])
               2'd0: return {1'b0, {(COORD_BITS-1){1'b1}}};
               2'd1: return {1'b1, {(COORD_BITS-1){1'b0}}};
               2'd2: return '0;
               default: return '1;
            endcase
         end
         default: return $signed(v[COORD_BITS-1:0]) >>> $urandom_range(COORD_BITS-1);
      endcase
   endfunction

   // mostly inside the grid in use, now and then anywhere
   function automatic logic [4:0] pick_index(int unsigned n);
      if (n == 0 || $urandom_range(9) == 0)
         return 5'($urandom_range(31));
      return 5'($urandom_range(n - 1));
   endfunction

   task automatic random_item();
      int unsigned nr, nc, k;
      logic [4:0] r, c, er, ec;
      logic signed [COORD_BITS-1:0] px, py, pz;
      nr = eff_count(rows_reg);
      nc = eff_count(cols_reg);
      r = pick_index(nr);
      c = pick_index(nc);
      er = pick_index(nr);
      ec = pick_index(nc);
      px = rand_coord();
      py = rand_coord();
      pz = rand_coord();
      k = $urandom_range(99);
      if (k < 35) begin
         send_item(OP_WRITE, r, c, er, ec, px, py, pz);
      end else if (k < 65) begin
         send_item(OP_PATH, r, c, er, ec, px, py, pz);
      end else if (k < 96) begin
         // aim near a stored point so the search has close rivals
         if ($urandom_range(1)) begin
            px = COORD_BITS'(grid_px[{r, c}] + ($urandom_range(64) - 32));
            py = COORD_BITS'(grid_py[{r, c}] + ($urandom_range(64) - 32));
            pz = grid_pz[{r, c}];
         end
         send_item(OP_NEAR, r, c, er, ec, px, py, pz);
      end else begin
         send_item(OP_NONE, r, c, er, ec, px, py, pz);
      end
   endtask

   task automatic test_register_reset();
      csr_read(REG_ROWS);
      csr_read(REG_COLS);
   endtask

   task automatic test_corner_points();
      logic signed [COORD_BITS-1:0] hi, lo;
      hi = {1'b0, {(COORD_BITS-1){1'b1}}};
      lo = {1'b1, {(COORD_BITS-1){1'b0}}};
      set_grid_size(6'd32, 6'd32);
      send_item(OP_WRITE, 5'd0, 5'd0, 5'd0, 5'd0, hi, hi, hi);
      send_item(OP_WRITE, 5'd31, 5'd31, 5'd31, 5'd31, lo, lo, lo);
      send_item(OP_WRITE, 5'd0, 5'd31, 5'd0, 5'd0, 24'h555555, 24'hAAAAAA, '0);
      send_item(OP_WRITE, 5'd31, 5'd30, 5'd0, 5'd0, '1, '1, '1);
      send_item(OP_PATH, 5'd0, 5'd0, 5'd31, 5'd31, '0, '0, '0);
      send_item(OP_PATH, 5'd31, 5'd31, 5'd0, 5'd0, '0, '0, '0);
      send_item(OP_PATH, 5'd31, 5'd0, 5'd0, 5'd31, '0, '0, '0);
      send_item(OP_PATH, 5'd5, 5'd7, 5'd5, 5'd7, '0, '0, '0);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, hi, hi, hi);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, lo, lo, lo);
      // all-zero cells tie, the first one in row order wins
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, '0, '0, '0);
      send_item(OP_NONE, 5'd31, 5'd31, 5'd31, 5'd31, hi, lo, hi);
      drain_results();
   endtask

   task automatic test_range_checks();
      set_grid_size(6'd4, 6'd5);
      send_item(OP_WRITE, 5'd4, 5'd0, 5'd0, 5'd0, 24'd100, 24'd200, 24'd300);
      send_item(OP_WRITE, 5'd0, 5'd5, 5'd0, 5'd0, 24'd100, 24'd200, 24'd300);
      send_item(OP_WRITE, 5'd3, 5'd4, 5'd0, 5'd0, 24'd100, -24'sd200, 24'd300);
      send_item(OP_PATH, 5'd0, 5'd0, 5'd4, 5'd1, '0, '0, '0);
      send_item(OP_PATH, 5'd0, 5'd6, 5'd0, 5'd0, '0, '0, '0);
      send_item(OP_PATH, 5'd3, 5'd4, 5'd0, 5'd0, '0, '0, '0);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, 24'd90, -24'sd190, 24'd290);
      drain_results();
   endtask

   task automatic test_empty_grid();
      set_grid_size(6'd0, 6'd7);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, 24'd1, 24'd2, 24'd3);
      send_item(OP_WRITE, 5'd0, 5'd0, 5'd0, 5'd0, 24'd1, 24'd2, 24'd3);
      drain_results();
      set_grid_size(6'd1, 6'd0);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, '1, '1, '1);
      drain_results();
   endtask

   task automatic test_single_column();
      // counts above the grid size behave as the full size
      set_grid_size(6'd63, 6'd1);
      send_item(OP_PATH, 5'd0, 5'd0, 5'd31, 5'd0, '0, '0, '0);
      send_item(OP_NEAR, 5'd0, 5'd0, 5'd0, 5'd0, '1, '1, '1);
      drain_results();
   endtask

   task automatic test_random_phase(input logic [CNT_BITS-1:0] rows, cols,
                                    input int n_items);
      set_grid_size(rows, cols);
      repeat (n_items) random_item();
      drain_results();
   endtask

   initial begin : run_tests
      logic [CNT_BITS-1:0] phase_rows [12];
      logic [CNT_BITS-1:0] phase_cols [12];
      int                  idle_pct [3];
      phase_rows = '{6'd32, 6'd3, 6'd1, 6'd0, 6'd63, 6'd6, 6'd2, 6'd32, 6'd5, 6'd1,
                     6'd32, 6'd8};
      phase_cols = '{6'd32, 6'd4, 6'd1, 6'd9, 6'd2, 6'd32, 6'd5, 6'd1, 6'd5, 6'd32,
                     6'd0, 6'd8};
      idle_pct = '{26, 83, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = idle_pct[0];
      test_register_reset();
      test_corner_points();
      test_range_checks();
      test_empty_grid();
      test_single_column();
      for (int m = 0; m < 3; m++) begin
         sender_idle_pct = idle_pct[m];
         for (int p = 0; p < 4; p++)
            test_random_phase(phase_rows[4*m+p], phase_cols[4*m+p], 34);
      end
      drain_results();
      mismatch_count += pending_results.size();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
